FILE: rtl/core/assert_macros.svh
// assertion helpers for the rtl files, included by stereo_chorus_flanger
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define SCF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/scf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_pkg
// types, constants and helper functions of the stereo chorus / flanger
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int DEF_DELAY_DEPTH  = 8192;
    localparam int DEF_SINE_ENTRIES = 1024;

    localparam int SAMPLE_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W = 48;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP = 3'd0,
        REG_BASE_DELAY = 3'd1,
        REG_DEPTH      = 3'd2,
        REG_FEEDBACK   = 3'd3,
        REG_WET_MIX    = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SINE, S_MDEP, S_DLY, S_POS, S_RDA, S_RDB,
        S_MA, S_MB, S_WET, S_MF, S_WR, S_MX1, S_MX2, S_RES, S_DONE
    } t_state;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [63:0] x);
        if (x > 64'sd8388607) begin
            return 24'sh7fffff;
        end else if (x < -64'sd8388608) begin
            return 24'sh800000;
        end
        return x[SAMPLE_W-1:0];
    endfunction

    // q1.15 sine of a 32-bit phase, taylor series in q30 (elaboration only)
    function automatic logic signed [15:0] sine_of_phase(input logic [31:0] p_in);
        logic        neg;
        logic [31:0] p;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        neg = 1'b0;
        p = p_in;
        if (p >= 32'h8000_0000) begin
            neg = 1'b1;
            p = p - 32'h8000_0000;
        end
        if (p > 32'h4000_0000) begin
            p = 32'h8000_0000 - p;
        end
        x = ({32'd0, p} * PI_Q30) >> 31;
        x2 = (x * x) >> 30;
        term = x;
        sum = signed'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (n % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32767) begin
            sum = 64'sd32767;
        end
        return neg ? -sum[15:0] : sum[15:0];
    endfunction

endpackage

FILE: rtl/core/stereo_chorus_flanger.sv
// one frame at a time: a new input beat is taken only after the previous
// frame's result has been loaded into the output register; both channels go in
// turn through the single shared multiplier and the delay memories
// reset: synchronous active low; a clearing pass writes zero to every address
// of both delay lines, during which no input beat is taken
// configuration registers reset to zero, wet_mix to half
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_chorus_flanger
// quadrature lfo chorus: modulated interpolated delay per channel, feedback
// into the ring and dry/wet mix, all on one shared multiplier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_chorus_flanger
    import scf_pkg::*;
#(
    parameter int DELAY_DEPTH  = DEF_DELAY_DEPTH,
    parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // left_in [23:0], right_in [47:24]
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata    // left_out [23:0], right_out [47:24]
);

    localparam int LW = $clog2(DELAY_DEPTH);
    localparam int SW = $clog2(SINE_ENTRIES);
    localparam int PW = LW + 16;           // delay / read position width, q16
    localparam logic signed [33:0] DLY_MIN   = 34'sd65536;
    localparam logic signed [33:0] DLY_LIMIT = 34'(DELAY_DEPTH - 1) << 16;
    localparam logic [PW-1:0]      DLY_CLAMP = PW'(DELAY_DEPTH - 2) << 16;

    // configuration registers
    logic [31:0]        r_phase_step;
    logic [28:0]        r_base_delay;
    logic [28:0]        r_depth;
    logic signed [15:0] r_feedback;
    logic [16:0]        r_wet_mix;

    // sequencer and datapath state
    t_state r_state, n_state;
    logic                         r_ch;
    logic [LW-1:0]                r_clr;
    logic [LW-1:0]                r_wi;
    logic [31:0]                  r_phase;
    logic signed [SAMPLE_W-1:0]   r_in_l, r_in_r;
    logic signed [15:0]           r_sin;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [PROD_W-1:0]     r_acc;
    logic [PW-1:0]                r_dly;
    logic [LW-1:0]                r_idx;
    logic [15:0]                  r_frac;
    logic signed [SAMPLE_W-1:0]   r_rd;
    logic signed [SAMPLE_W-1:0]   r_a;
    logic signed [SAMPLE_W-1:0]   r_wet;
    logic signed [SAMPLE_W-1:0]   r_res_l, r_res_r;
    logic                         r_mvalid;
    logic [47:0]                  r_mdata;

    // delay lines
    logic signed [SAMPLE_W-1:0] r_left_line  [DELAY_DEPTH];
    logic signed [SAMPLE_W-1:0] r_right_line [DELAY_DEPTH];

    // sine table, built at elaboration
    logic signed [15:0] w_sine [SINE_ENTRIES];
    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
        localparam logic signed [15:0] SINE_K = sine_of_phase(32'(k) << (32 - SW));
        assign w_sine[k] = SINE_K;
    end

    logic [31:0]                w_ch_phase;
    logic [SW-1:0]              w_si;
    logic [16:0]                w_mix;
    logic signed [SAMPLE_W-1:0] w_in;
    logic signed [29:0]         w_ma;
    logic signed [17:0]         w_mb;
    logic signed [PROD_W-1:0]   w_prod;
    logic [LW-1:0]              w_raddr;
    logic                       w_we_l, w_we_r;
    logic [LW-1:0]              w_waddr;
    logic signed [SAMPLE_W-1:0] w_wdata;
    logic                       w_load_out;
    logic signed [33:0]         w_delay;
    logic signed [PROD_W:0]     w_sum;
    logic signed [SAMPLE_W-1:0] w_fb_wr;

    // right lfo leads by a quarter turn
    assign w_ch_phase = r_phase + (r_ch ? 32'h4000_0000 : 32'h0);
    assign w_si       = w_ch_phase[31 -: SW];
    assign w_mix      = (r_wet_mix > 17'd65536) ? 17'd65536 : r_wet_mix;
    assign w_in       = r_ch ? r_in_r : r_in_l;
    assign w_prod     = PROD_W'(w_ma) * PROD_W'(w_mb);
    assign w_load_out = (r_state == S_DONE) && (!r_mvalid || m_tready);

    // delay = base + round(depth * sine / 2^15)
    assign w_delay = 34'(signed'({1'b0, r_base_delay}))
                   + 34'((r_prod + 48'sd16384) >>> 15);
    assign w_sum   = (PROD_W+1)'(r_acc) + (PROD_W+1)'(r_prod)
                   + (PROD_W+1)'(49'sd32768);
    assign w_fb_wr = sat24(64'(w_in) + 64'((r_prod + 48'sd16384) >>> 15));

    // configuration writes, expected only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_base_delay <= '0;
            r_depth      <= '0;
            r_feedback   <= '0;
            r_wet_mix    <= 17'd32768;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_PHASE_STEP: r_phase_step <= i_cfg_wdata;
                REG_BASE_DELAY: r_base_delay <= i_cfg_wdata[28:0];
                REG_DEPTH:      r_depth      <= i_cfg_wdata[28:0];
                REG_FEEDBACK:   r_feedback   <= i_cfg_wdata[15:0];
                REG_WET_MIX:    r_wet_mix    <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == LW'(DELAY_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (s_tvalid) n_state = S_SINE;
            S_SINE:  n_state = S_MDEP;
            S_MDEP:  n_state = S_DLY;
            S_DLY:   n_state = S_POS;
            S_POS:   n_state = S_RDA;
            S_RDA:   n_state = S_RDB;
            S_RDB:   n_state = S_MA;
            S_MA:    n_state = S_MB;
            S_MB:    n_state = S_WET;
            S_WET:   n_state = S_MF;
            S_MF:    n_state = S_WR;
            S_WR:    n_state = S_MX1;
            S_MX1:   n_state = S_MX2;
            S_MX2:   n_state = S_RES;
            S_RES:   n_state = r_ch ? S_DONE : S_SINE;
            S_DONE:  if (w_load_out) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // control decode: handshake, multiplier operands, memory ports
    always_comb begin
        s_tready = (r_state == S_IDLE);
        w_ma     = '0;
        w_mb     = '0;
        w_raddr  = (r_state == S_RDA) ? r_idx : r_idx + LW'(1);
        w_we_l   = 1'b0;
        w_we_r   = 1'b0;
        w_waddr  = r_wi;
        w_wdata  = w_fb_wr;
        case (r_state)
            S_CLEAR: begin
                w_we_l  = 1'b1;
                w_we_r  = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_MDEP: begin
                w_ma = signed'({1'b0, r_depth});
                w_mb = 18'(r_sin);
            end
            S_MA: begin
                w_ma = 30'(r_a);
                w_mb = signed'({1'b0, 17'd65536 - {1'b0, r_frac}});
            end
            S_MB: begin
                w_ma = 30'(r_rd);
                w_mb = signed'({2'b0, r_frac});
            end
            S_MF: begin
                w_ma = 30'(r_wet);
                w_mb = 18'(r_feedback);
            end
            S_WR: begin
                w_we_l = !r_ch;
                w_we_r = r_ch;
            end
            S_MX1: begin
                w_ma = 30'(w_in);
                w_mb = signed'({1'b0, 17'd65536 - w_mix});
            end
            S_MX2: begin
                w_ma = 30'(r_wet);
                w_mb = signed'({1'b0, w_mix});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ch     <= 1'b0;
            r_wi     <= '0;
            r_phase  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + LW'(1);
            end
            if (r_state == S_RES) begin
                r_ch <= !r_ch;
            end
            if (m_tvalid && m_tready) begin
                r_mvalid <= 1'b0;
            end
            if (w_load_out) begin
                r_mvalid <= 1'b1;
                r_wi     <= r_wi + LW'(1);
                r_phase  <= r_phase + r_phase_step;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (s_tvalid && s_tready) begin
            r_in_l <= s_tdata[23:0];
            r_in_r <= s_tdata[47:24];
        end
        case (r_state)
            S_SINE: r_sin <= w_sine[w_si];
            S_DLY: begin
                // clamp below one sample to one sample, and from depth minus one sample up to depth minus two
                if (w_delay < DLY_MIN) begin
                    r_dly <= PW'(DLY_MIN);
                end else if (w_delay >= DLY_LIMIT) begin
                    r_dly <= DLY_CLAMP;
                end else begin
                    r_dly <= w_delay[PW-1:0];
                end
            end
            S_POS: begin
                // ring wrap falls out of the modulo-2^PW subtract
                {r_idx, r_frac} <= {r_wi, 16'd0} - r_dly;
            end
            S_RDB: r_a <= r_rd;
            S_MB:  r_acc <= r_prod;
            S_WET: r_wet <= w_sum[SAMPLE_W+15:16];
            S_MX2: r_acc <= r_prod;
            S_RES: begin
                if (r_ch) begin
                    r_res_r <= sat24(64'(w_sum >>> 16));
                end else begin
                    r_res_l <= sat24(64'(w_sum >>> 16));
                end
            end
            default: ;
        endcase
        if (w_load_out) begin
            r_mdata <= {r_res_r, r_res_l};
        end
    end

    // delay line memories
    always_ff @(posedge i_clk) begin
        if (w_we_l) begin
            r_left_line[w_waddr] <= w_wdata;
        end
        if (w_we_r) begin
            r_right_line[w_waddr] <= w_wdata;
        end
        r_rd <= r_ch ? r_right_line[w_raddr] : r_left_line[w_raddr];
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;

    `SCF_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
    `SCF_NEVER(a_no_out_in_clear, (r_state == S_CLEAR) && m_tvalid, "output during clear")
    `SCF_ASSERT(a_load_shows, w_load_out |=> (m_tvalid && (r_state == S_IDLE)), "result not shown")
    `SCF_NEVER(a_ch_idle, r_ch && (r_state == S_IDLE), "channel select left set")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stereo chorus / flanger: frames go in over the
// slave stream, a frame-by-frame model of the modulated delay lines predicts
// every output beat, and the master stream is compared beat by beat under
// random idling on both sides and several register settings
// ----------------------------------------------------------------------------
module tb_top;
    import scf_pkg::*;

    localparam int LINE_LEN = DEF_DELAY_DEPTH;
    localparam int SINE_LEN = DEF_SINE_ENTRIES;

    // frame-level model of the effect plus the queue of frames still owed
    class chorus_scoreboard;
        logic signed [23:0] ring [2][LINE_LEN];
        logic signed [15:0] sine_rom [SINE_LEN];
        logic [12:0]        wr_ptr;
        logic [31:0]        lfo;
        logic [31:0]        step_r;
        logic [28:0]        base_r;
        logic [28:0]        depth_r;
        logic signed [15:0] fb_r;
        logic [16:0]        mix_r;
        logic [47:0]        owed [$];

        function new();
            for (int k = 0; k < SINE_LEN; k++) begin
                sine_rom[k] = sine_q15(32'((64'(k) << 32) / SINE_LEN));
            end
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < LINE_LEN; i++) begin
                    ring[c][i] = '0;
                end
            end
            wr_ptr = '0;
            lfo = '0;
            step_r = '0;
            base_r = '0;
            depth_r = '0;
            fb_r = '0;
            mix_r = 17'd32768;
        endfunction

        // quarter-wave fold, then a taylor series in q30, rounded to q15
        function logic signed [15:0] sine_q15(logic [31:0] ph);
            bit          negative;
            logic [63:0] rad;
            logic [63:0] rad2;
            logic [63:0] t;
            longint      acc;
            negative = 0;
            if (ph >= 32'h8000_0000) begin
                negative = 1;
                ph = ph - 32'h8000_0000;
            end
            if (ph > 32'h4000_0000) begin
                ph = 32'h8000_0000 - ph;
            end
            rad = (64'(ph) * 64'd3373259426) >> 31;
            rad2 = (rad * rad) >> 30;
            t = rad;
            acc = longint'(rad);
            for (int n = 1; n <= 6; n++) begin
                t = ((t * rad2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(t);
                end else begin
                    acc = acc + longint'(t);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc + 16384) >>> 15;
            if (acc > 32767) begin
                acc = 32767;
            end
            return negative ? 16'(-acc) : 16'(acc);
        endfunction

        function longint clip24(longint v);
            if (v > 8388607) begin
                return 8388607;
            end
            if (v < -8388608) begin
                return -8388608;
            end
            return v;
        endfunction

        function longint rnd(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_PHASE_STEP: step_r = val;
                REG_BASE_DELAY: base_r = val[28:0];
                REG_DEPTH:      depth_r = val[28:0];
                REG_FEEDBACK:   fb_r = val[15:0];
                REG_WET_MIX:    mix_r = val[16:0];
                default: ;
            endcase
        endfunction

        // one channel: interpolated tap, ring write with feedback, dry/wet mix
        function logic [23:0] voice(int ch, logic signed [23:0] smp, logic [31:0] ph);
            longint dly;
            longint pos;
            longint wet;
            longint a;
            longint b;
            longint m;
            int     tap;
            int     frac;
            dly = longint'(base_r) + rnd(longint'(depth_r) * longint'(sine_rom[ph[31:22]]), 15);
            if (dly < (longint'(1) << 16)) begin
                dly = longint'(1) << 16;
            end
            if (dly >= (longint'(LINE_LEN - 1) << 16)) begin
                dly = longint'(LINE_LEN - 2) << 16;
            end
            pos = (longint'(wr_ptr) << 16) - dly;
            if (pos < 0) begin
                pos += longint'(LINE_LEN) << 16;
            end
            tap = int'((pos >> 16) % LINE_LEN);
            frac = int'(pos & 64'hffff);
            a = ring[ch][tap];
            b = ring[ch][(tap + 1) % LINE_LEN];
            wet = rnd(a * (65536 - frac) + b * frac, 16);
            ring[ch][wr_ptr] = 24'(clip24(longint'(smp) + rnd(wet * longint'(fb_r), 15)));
            m = (mix_r > 17'd65536) ? 65536 : longint'(mix_r);
            return 24'(clip24(rnd(longint'(smp) * (65536 - m) + wet * m, 16)));
        endfunction

        function void note_frame(logic [47:0] beat);
            logic [23:0] lo;
            logic [23:0] ro;
            lo = voice(0, beat[23:0], lfo);
            ro = voice(1, beat[47:24], lfo + 32'h4000_0000);
            owed.push_back({ro, lo});
            wr_ptr = wr_ptr + 1'b1;
            lfo = lfo + step_r;
        endfunction

        // returns an empty string when the beat matches the oldest frame owed
        function string check_frame(logic [47:0] beat);
            logic [47:0] want;
            string       msg;
            if (owed.size() == 0) begin
                return $sformatf("output beat %h with no frame owed", beat);
            end
            want = owed.pop_front();
            msg = "";
            if (beat[23:0] !== want[23:0]) begin
                msg = $sformatf("left_out %h, want %h ", beat[23:0], want[23:0]);
            end
            if (beat[47:24] !== want[47:24]) begin
                msg = {msg, $sformatf("right_out %h, want %h", beat[47:24], want[47:24])};
            end
            return msg;
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;   // left_in [23:0], right_in [47:24]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;   // left_out [23:0], right_out [47:24]

    chorus_scoreboard sb;
    int mismatches;
    int send_idle_pct;
    int sink_stall_pct;

    stereo_chorus_flanger uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // output side: check each accepted beat, then pick next cycle's ready
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && m_tvalid && m_tready) begin
            msg = sb.check_frame(m_tdata);
            if (msg != "") begin
                report(msg);
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // one frame onto the input stream, with random idle cycles ahead of it
    task automatic send_frame(logic [23:0] left_smp, logic [23:0] right_smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {right_smp, left_smp};
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        sb.note_frame({right_smp, left_smp});
    endtask

    // drain the pipeline so a register write never lands mid-frame
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic setup(logic [31:0] stp, logic [31:0] bd, logic [31:0] dp,
                         logic [31:0] fb, logic [31:0] mx);
        wait_drained();
        write_reg(REG_PHASE_STEP, stp);
        write_reg(REG_BASE_DELAY, bd);
        write_reg(REG_DEPTH, dp);
        write_reg(REG_FEEDBACK, fb);
        write_reg(REG_WET_MIX, mx);
    endtask

    function automatic logic [23:0] any_sample();
        case ($urandom_range(5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    // mostly musical settings with short delays, now and then the far ends
    task automatic random_setup();
        logic [31:0] stp;
        logic [31:0] bd;
        logic [31:0] dp;
        logic [31:0] mx;
        stp = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000);
        bd = ($urandom_range(5) == 0) ? $urandom : $urandom_range(48 << 16);
        dp = ($urandom_range(5) == 0) ? $urandom : $urandom_range(40 << 16);
        mx = ($urandom_range(4) == 0) ? $urandom_range(131071) : $urandom_range(65536);
        setup(stp, bd, dp, $urandom, mx);
    endtask

    initial begin
        sb = new();
        mismatches = 0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field extremes through the default half mix
        send_frame(24'h7fffff, 24'h800000);
        send_frame(24'h800000, 24'h7fffff);
        send_frame(24'h000000, 24'hffffff);
        send_frame(24'h555555, 24'haaaaaa);

        // delay too short, mix above unity, full positive feedback,
        // plus writes to unknown register indexes that must change nothing
        setup(32'd0, 32'd0, 32'd0, 32'h7fff, 32'h1ffff);
        write_reg(3'd5, 32'hffffffff);
        write_reg(3'd6, 32'h12345678);
        write_reg(3'd7, 32'hffffffff);
        repeat (4) send_frame(24'h7fffff, 24'h800000);
        send_frame(24'h123456, 24'hedcba9);

        // delay too long, full negative feedback, dry only, largest phase step
        setup(32'hffffffff, 32'h1fffffff, 32'h1fffffff, 32'h8000, 32'd0);
        repeat (3) send_frame(24'h800000, 24'h7fffff);

        // full depth swing around a short centre, exactly unity wet
        setup(32'h1000_0000, 32'd8 << 16, 32'h1fffffff, 32'h4000, 32'd65536);
        repeat (8) send_frame(any_sample(), any_sample());

        // random phases: steady, sparse sender, slow sink, both idle
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin send_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                random_setup();
                for (int n = 0; n < 135; n++) begin
                    if (ph == 2 && sub == 0 && n == 60) begin
                        // hold off until the block has handed back everything
                        s_tvalid <= 1'b0;
                        while (sb.pending() != 0) begin
                            @(posedge i_clk);
                        end
                    end
                    send_frame(any_sample(), any_sample());
                end
            end
        end

        s_tvalid <= 1'b0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far past the slowest legal run
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/scf_pkg.sv
rtl/core/stereo_chorus_flanger.sv
test/tb_top.sv
